// ----- hw/rtl/dbr_pkg.sv -----
package dbr_pkg;

	// Width of the normalized depth code; the all-ones code is the far plane.
	localparam int DEPTH_BITS = 24;
	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

	// Quotient and result width (Q16.16 distances).
	localparam int Q_BITS = 32;

	// Eye depth division: numerator f*n*D, divisor f*(D-c)+n*c.
	localparam int FN_BITS = 48;
	localparam int ZN_BITS = FN_BITS + DEPTH_BITS;
	localparam int ZD_BITS = 24 + DEPTH_BITS;

	// Lateral division: numerator ze*u*|ext|, divisor size*near.
	localparam int U_BITS  = 14;
	localparam int UM_BITS = 36;
	localparam int UM_HALF = UM_BITS / 2;
	localparam int LP_BITS = Q_BITS + UM_HALF;
	localparam int LN_BITS = Q_BITS + UM_BITS;
	localparam int LD_BITS = 36;

	// Square root of the sum of three squares.
	localparam int SQ_BITS   = 2 * Q_BITS;
	localparam int SUM_BITS  = SQ_BITS + 2;
	localparam int ROOT_BITS = SUM_BITS / 2;
	localparam int REM_BITS  = ROOT_BITS + 2;

	// Register stages from input acceptance to the output register.
	localparam int N_STAGES = 2 + (Q_BITS + 1) + 2 + (Q_BITS + 1) + 1 + (ROOT_BITS + 1) + 1;

	typedef enum logic [2:0] {
		REG_NEAR,
		REG_FAR,
		REG_LEFT,
		REG_BOTTOM,
		REG_WIDTH,
		REG_HEIGHT,
		REG_CROP_X0,
		REG_CROP_Y0
	} reg_idx_t;

	typedef struct packed {
		logic [11:0]           col_offset;
		logic [11:0]           row_offset;
		logic [DEPTH_BITS-1:0] depth_code;
		logic                  frame_end;
	} pix_t;

	typedef struct packed {
		logic [Q_BITS-1:0] range_m;
		logic              range_valid;
		logic              frame_end_out;
	} rng_t;

endpackage

// ----- hw/rtl/depth_buffer_to_range_core.sv -----
// Depth buffer to euclidean range converter.
// Input channel pix (pix_valid/pix_ready) carries one depth buffer pixel per
// transaction: its column and row inside the crop window, the normalized depth
// code and the last-pixel mark. Output channel rng (rng_valid/rng_ready) returns
// exactly one transaction per pixel, in order: the range in Q16.16 meters,
// a flag that is low for a far-plane code, and the copied last-pixel mark.
// The conversion is a fixed pipeline of 106 register stages, and a new pixel is
// taken in every cycle unless the output is stalled. The length comes from the
// bit-serial stages: 33 for the eye depth divider, 33 for the two lateral
// dividers working side by side, and 34 for the square root.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// pix_ready falls in the same cycle; no pixel is lost or repeated.
// Reset empties the pipeline and loads the default camera setup. The APB port
// writes the camera registers at byte address 4*index; it must only be written
// while no pixel is in flight.
module depth_buffer_to_range_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pix_valid,
	output logic               pix_ready,
	input  dbr_pkg::pix_t      pix,
	output logic               rng_valid,
	input  logic               rng_ready,
	output dbr_pkg::rng_t      rng,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import dbr_pkg::*;

	typedef struct packed {
		logic [FN_BITS-1:0] fn;
		logic [ZD_BITS-1:0] fd;
		logic [ZD_BITS-1:0] nc;
		logic [U_BITS-1:0]  ux;
		logic [U_BITS-1:0]  uy;
		logic [LD_BITS-1:0] dx;
		logic [LD_BITS-1:0] dy;
		logic               far;
		logic               fe;
	} st1_t;

	typedef struct packed {
		logic [UM_BITS-1:0] umx;
		logic [UM_BITS-1:0] umy;
		logic [LD_BITS-1:0] dx;
		logic [LD_BITS-1:0] dy;
		logic               far;
		logic               fe;
	} side_t;

	typedef struct packed {
		logic [ZN_BITS-1:0] num;
		logic [ZD_BITS-1:0] den;
		side_t              sd;
	} st2_t;

	typedef struct packed {
		logic [ZD_BITS-1:0] rem;
		logic [Q_BITS-1:0]  low;
		logic [Q_BITS-1:0]  q;
		logic [ZD_BITS-1:0] den;
		logic               ov;
	} zdiv_t;

	typedef struct packed {
		logic [Q_BITS-1:0]  ze;
		logic [LP_BITS-1:0] pxl;
		logic [LP_BITS-1:0] pxh;
		logic [LP_BITS-1:0] pyl;
		logic [LP_BITS-1:0] pyh;
		logic [LD_BITS-1:0] dx;
		logic [LD_BITS-1:0] dy;
		logic               ov;
		logic               far;
		logic               fe;
	} lat1_t;

	typedef struct packed {
		logic [Q_BITS-1:0]  ze;
		logic [LN_BITS-1:0] nx;
		logic [LN_BITS-1:0] ny;
		logic [LD_BITS-1:0] dx;
		logic [LD_BITS-1:0] dy;
		logic               ov;
		logic               far;
		logic               fe;
	} lat2_t;

	typedef struct packed {
		logic [LD_BITS-1:0] rem;
		logic [Q_BITS-1:0]  low;
		logic [Q_BITS-1:0]  q;
		logic [LD_BITS-1:0] den;
		logic               ov;
	} lane_t;

	typedef struct packed {
		logic [Q_BITS-1:0] ze;
		logic              ov;
		logic              far;
		logic              fe;
	} xside_t;

	typedef struct packed {
		logic [SQ_BITS-1:0] sx;
		logic [SQ_BITS-1:0] sy;
		logic [SQ_BITS-1:0] sz;
		logic               ov;
		logic               far;
		logic               fe;
	} sqr_t;

	typedef struct packed {
		logic [REM_BITS-1:0]  rem;
		logic [ROOT_BITS-1:0] root;
		logic [SUM_BITS-1:0]  src;
		logic                 ov;
		logic                 far;
		logic                 fe;
	} root_t;

	// Division steps: the quotient is known to fit in Q_BITS once the upper
	// part of the numerator is below the divisor, so only Q_BITS steps remain.
	function automatic zdiv_t zdiv_init(logic [ZN_BITS-1:0] n, logic [ZD_BITS-1:0] d);
		zdiv_t r;
		logic [ZD_BITS-1:0] hi;
		hi = ZD_BITS'(n[ZN_BITS-1:Q_BITS]);
		r.rem = hi;
		r.low = n[Q_BITS-1:0];
		r.q   = '0;
		r.den = d;
		r.ov  = (d == '0) || (hi >= d);
		return r;
	endfunction

	function automatic zdiv_t zdiv_step(zdiv_t a);
		zdiv_t r;
		logic [ZD_BITS:0] t;
		logic ge;
		r  = a;
		t  = {a.rem, a.low[Q_BITS-1]};
		ge = (t >= {1'b0, a.den});
		r.rem = ge ? ZD_BITS'(t - {1'b0, a.den}) : t[ZD_BITS-1:0];
		r.q   = {a.q[Q_BITS-2:0], ge};
		r.low = {a.low[Q_BITS-2:0], 1'b0};
		return r;
	endfunction

	function automatic lane_t lane_init(logic [LN_BITS-1:0] n, logic [LD_BITS-1:0] d);
		lane_t r;
		logic [LD_BITS-1:0] hi;
		hi = LD_BITS'(n[LN_BITS-1:Q_BITS]);
		r.rem = hi;
		r.low = n[Q_BITS-1:0];
		r.q   = '0;
		r.den = d;
		r.ov  = (d == '0) || (hi >= d);
		return r;
	endfunction

	function automatic lane_t lane_step(lane_t a);
		lane_t r;
		logic [LD_BITS:0] t;
		logic ge;
		r  = a;
		t  = {a.rem, a.low[Q_BITS-1]};
		ge = (t >= {1'b0, a.den});
		r.rem = ge ? LD_BITS'(t - {1'b0, a.den}) : t[LD_BITS-1:0];
		r.q   = {a.q[Q_BITS-2:0], ge};
		r.low = {a.low[Q_BITS-2:0], 1'b0};
		return r;
	endfunction

	// One digit of the restoring square root: two radicand bits per step.
	function automatic root_t root_step(root_t a);
		root_t r;
		logic [REM_BITS+1:0] t;
		logic [REM_BITS+1:0] trial;
		logic ge;
		r     = a;
		t     = {a.rem, a.src[SUM_BITS-1 -: 2]};
		trial = (REM_BITS + 2)'({a.root, 2'b01});
		ge    = (t >= trial);
		r.rem  = ge ? REM_BITS'(t - trial) : t[REM_BITS-1:0];
		r.root = {a.root[ROOT_BITS-2:0], ge};
		r.src  = {a.src[SUM_BITS-3:0], 2'b00};
		return r;
	endfunction

	function automatic logic [U_BITS-1:0] offset_mag(logic [11:0] pos, logic [11:0] org,
			logic [11:0] size);
		logic [U_BITS-1:0] twice;
		logic [U_BITS-1:0] sz;
		twice = U_BITS'({1'b0, pos} + {1'b0, org}) << 1;
		sz    = U_BITS'(size);
		return (twice >= sz) ? U_BITS'(twice - sz) : U_BITS'(sz - twice);
	endfunction

	// Configuration registers.
	logic [23:0] near_q;
	logic [23:0] far_q;
	logic [21:0] left_q;
	logic [21:0] bottom_q;
	logic [11:0] width_q;
	logic [11:0] height_q;
	logic [11:0] crop_x0_q;
	logic [11:0] crop_y0_q;

	logic        wr_en;
	reg_idx_t    reg_idx;
	logic [21:0] left_mag;
	logic [21:0] bottom_mag;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q    <= 24'd32768;
			far_q     <= 24'd327680;
			// Two's complement of -17790 and -13336 in 22 bits.
			left_q    <= 22'h3FBA82;
			bottom_q  <= 22'h3FCBE8;
			width_q   <= 12'd640;
			height_q  <= 12'd480;
			crop_x0_q <= 12'd0;
			crop_y0_q <= 12'd0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_NEAR:    near_q    <= pwdata[23:0];
				REG_FAR:     far_q     <= pwdata[23:0];
				REG_LEFT:    left_q    <= pwdata[21:0];
				REG_BOTTOM:  bottom_q  <= pwdata[21:0];
				REG_WIDTH:   width_q   <= pwdata[11:0];
				REG_HEIGHT:  height_q  <= pwdata[11:0];
				REG_CROP_X0: crop_x0_q <= pwdata[11:0];
				REG_CROP_Y0: crop_y0_q <= pwdata[11:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_NEAR:    prdata = {8'd0, near_q};
			REG_FAR:     prdata = {8'd0, far_q};
			REG_LEFT:    prdata = {10'd0, left_q};
			REG_BOTTOM:  prdata = {10'd0, bottom_q};
			REG_WIDTH:   prdata = {20'd0, width_q};
			REG_HEIGHT:  prdata = {20'd0, height_q};
			REG_CROP_X0: prdata = {20'd0, crop_x0_q};
			REG_CROP_Y0: prdata = {20'd0, crop_y0_q};
		endcase
	end

	// Only the magnitude of the frustum extents enters the range.
	assign left_mag   = left_q[21] ? 22'(~left_q + 22'd1) : left_q;
	assign bottom_mag = bottom_q[21] ? 22'(~bottom_q + 22'd1) : bottom_q;

	// Pipeline control: every stage advances together unless the output is stalled.
	logic [N_STAGES-1:0] vld_q;
	logic                adv;

	assign adv       = !vld_q[N_STAGES-1] || rng_ready;
	assign pix_ready = adv;
	assign rng_valid = vld_q[N_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[N_STAGES-2:0], pix_valid};
		end
	end

	st1_t   st1_s1;
	st2_t   st2_s2;
	zdiv_t  zdiv_s3  [Q_BITS+1];
	side_t  zside_s3 [Q_BITS+1];
	lat1_t  lat_s36;
	lat2_t  lat_s37;
	lane_t  xdiv_s38 [Q_BITS+1];
	lane_t  ydiv_s38 [Q_BITS+1];
	xside_t xside_s38[Q_BITS+1];
	sqr_t   sqr_s71;
	root_t  root_s72 [ROOT_BITS+1];
	rng_t   out_s106;

	logic [Q_BITS-1:0] ze_end;
	logic [Q_BITS-1:0] xe_end;
	logic [Q_BITS-1:0] ye_end;

	always_ff @(posedge clk) begin
		if (adv) begin
			st1_s1.fn  <= FN_BITS'(far_q) * FN_BITS'(near_q);
			st1_s1.fd  <= ZD_BITS'(far_q) * ZD_BITS'(DEPTH_MAX - pix.depth_code);
			st1_s1.nc  <= ZD_BITS'(near_q) * ZD_BITS'(pix.depth_code);
			st1_s1.ux  <= offset_mag(pix.col_offset, crop_x0_q, width_q);
			st1_s1.uy  <= offset_mag(pix.row_offset, crop_y0_q, height_q);
			st1_s1.dx  <= LD_BITS'(width_q) * LD_BITS'(near_q);
			st1_s1.dy  <= LD_BITS'(height_q) * LD_BITS'(near_q);
			st1_s1.far <= (pix.depth_code == DEPTH_MAX);
			st1_s1.fe  <= pix.frame_end;

			// f*n*D with D all ones is a shift and a subtract.
			st2_s2.num    <= (ZN_BITS'(st1_s1.fn) << DEPTH_BITS) - ZN_BITS'(st1_s1.fn);
			st2_s2.den    <= ZD_BITS'(st1_s1.fd + st1_s1.nc);
			st2_s2.sd.umx <= UM_BITS'(st1_s1.ux) * UM_BITS'(left_mag);
			st2_s2.sd.umy <= UM_BITS'(st1_s1.uy) * UM_BITS'(bottom_mag);
			st2_s2.sd.dx  <= st1_s1.dx;
			st2_s2.sd.dy  <= st1_s1.dy;
			st2_s2.sd.far <= st1_s1.far;
			st2_s2.sd.fe  <= st1_s1.fe;

			zdiv_s3[0]  <= zdiv_init(st2_s2.num, st2_s2.den);
			zside_s3[0] <= st2_s2.sd;
		end
	end

	for (genvar i = 1; i <= Q_BITS; i++) begin : g_zdiv
		always_ff @(posedge clk) begin
			if (adv) begin
				zdiv_s3[i]  <= zdiv_step(zdiv_s3[i-1]);
				zside_s3[i] <= zside_s3[i-1];
			end
		end
	end

	assign ze_end = zdiv_s3[Q_BITS].ov ? '1 : zdiv_s3[Q_BITS].q;

	always_ff @(posedge clk) begin
		if (adv) begin
			// The 36-bit lateral factor is split in halves to keep each product narrow.
			lat_s36.ze  <= ze_end;
			lat_s36.pxl <= LP_BITS'(ze_end) * LP_BITS'(zside_s3[Q_BITS].umx[UM_HALF-1:0]);
			lat_s36.pxh <= LP_BITS'(ze_end) * LP_BITS'(zside_s3[Q_BITS].umx[UM_BITS-1:UM_HALF]);
			lat_s36.pyl <= LP_BITS'(ze_end) * LP_BITS'(zside_s3[Q_BITS].umy[UM_HALF-1:0]);
			lat_s36.pyh <= LP_BITS'(ze_end) * LP_BITS'(zside_s3[Q_BITS].umy[UM_BITS-1:UM_HALF]);
			lat_s36.dx  <= zside_s3[Q_BITS].dx;
			lat_s36.dy  <= zside_s3[Q_BITS].dy;
			lat_s36.ov  <= zdiv_s3[Q_BITS].ov;
			lat_s36.far <= zside_s3[Q_BITS].far;
			lat_s36.fe  <= zside_s3[Q_BITS].fe;

			lat_s37.ze  <= lat_s36.ze;
			lat_s37.nx  <= LN_BITS'(lat_s36.pxl) + (LN_BITS'(lat_s36.pxh) << UM_HALF);
			lat_s37.ny  <= LN_BITS'(lat_s36.pyl) + (LN_BITS'(lat_s36.pyh) << UM_HALF);
			lat_s37.dx  <= lat_s36.dx;
			lat_s37.dy  <= lat_s36.dy;
			lat_s37.ov  <= lat_s36.ov;
			lat_s37.far <= lat_s36.far;
			lat_s37.fe  <= lat_s36.fe;

			xdiv_s38[0]      <= lane_init(lat_s37.nx, lat_s37.dx);
			ydiv_s38[0]      <= lane_init(lat_s37.ny, lat_s37.dy);
			xside_s38[0].ze  <= lat_s37.ze;
			xside_s38[0].ov  <= lat_s37.ov;
			xside_s38[0].far <= lat_s37.far;
			xside_s38[0].fe  <= lat_s37.fe;
		end
	end

	for (genvar i = 1; i <= Q_BITS; i++) begin : g_xdiv
		always_ff @(posedge clk) begin
			if (adv) begin
				xdiv_s38[i]  <= lane_step(xdiv_s38[i-1]);
				ydiv_s38[i]  <= lane_step(ydiv_s38[i-1]);
				xside_s38[i] <= xside_s38[i-1];
			end
		end
	end

	assign xe_end = xdiv_s38[Q_BITS].ov ? '1 : xdiv_s38[Q_BITS].q;
	assign ye_end = ydiv_s38[Q_BITS].ov ? '1 : ydiv_s38[Q_BITS].q;

	always_ff @(posedge clk) begin
		if (adv) begin
			sqr_s71.sx  <= SQ_BITS'(xe_end) * SQ_BITS'(xe_end);
			sqr_s71.sy  <= SQ_BITS'(ye_end) * SQ_BITS'(ye_end);
			sqr_s71.sz  <= SQ_BITS'(xside_s38[Q_BITS].ze) * SQ_BITS'(xside_s38[Q_BITS].ze);
			sqr_s71.ov  <= xside_s38[Q_BITS].ov || xdiv_s38[Q_BITS].ov || ydiv_s38[Q_BITS].ov;
			sqr_s71.far <= xside_s38[Q_BITS].far;
			sqr_s71.fe  <= xside_s38[Q_BITS].fe;

			root_s72[0].rem  <= '0;
			root_s72[0].root <= '0;
			root_s72[0].src  <= SUM_BITS'(sqr_s71.sx) + SUM_BITS'(sqr_s71.sy)
				+ SUM_BITS'(sqr_s71.sz);
			root_s72[0].ov   <= sqr_s71.ov;
			root_s72[0].far  <= sqr_s71.far;
			root_s72[0].fe   <= sqr_s71.fe;
		end
	end

	for (genvar i = 1; i <= ROOT_BITS; i++) begin : g_root
		always_ff @(posedge clk) begin
			if (adv) begin
				root_s72[i] <= root_step(root_s72[i-1]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (root_s72[ROOT_BITS].far) begin
				out_s106.range_m <= '0;
			end else if (root_s72[ROOT_BITS].ov || root_s72[ROOT_BITS].root[ROOT_BITS-1]) begin
				out_s106.range_m <= '1;
			end else begin
				out_s106.range_m <= root_s72[ROOT_BITS].root[Q_BITS-1:0];
			end
			out_s106.range_valid   <= !root_s72[ROOT_BITS].far;
			out_s106.frame_end_out <= root_s72[ROOT_BITS].fe;
		end
	end

	assign rng = out_s106;

endmodule

// ----- hw/rtl/dbr_checker.sv -----
module dbr_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          pix_valid,
	input logic          pix_ready,
	input dbr_pkg::pix_t pix,
	input logic          rng_valid,
	input logic          rng_ready,
	input dbr_pkg::rng_t rng
);
	import dbr_pkg::*;

	// A stalled result holds until it is taken.
	a_rng_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rng_valid && !rng_ready |=> rng_valid && $stable(rng))
		else $error("stalled range transaction changed");

	// A far-plane pixel always reports a zero range.
	a_far_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rng_valid && !rng.range_valid |-> rng.range_m == '0)
		else $error("far-plane result with nonzero range");

	// The input is refused exactly when a result waits on a stalled receiver.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pix_ready == (!rng_valid || rng_ready))
		else $error("pixel ready does not follow output stall");

	// Nothing comes out at the clock edge where reset is first seen released.
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !rng_valid)
		else $error("range transaction right after reset");

endmodule

bind depth_buffer_to_range_core dbr_checker u_dbr_checker (.*);
